// ===== sv/mcld_pkg.sv =====
package mcld_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned MAG_W   = 9;
    localparam int unsigned DUTY_W  = 8;
    localparam int unsigned OUT_W   = 24;

    localparam logic [CHAR_W-1:0] CHAR_NL    = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'd43;
    localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'd44;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;
    localparam logic [CHAR_W-1:0] CHAR_M     = 8'd77;

    localparam logic [MAG_W-1:0]  MAG_SAT    = 9'd256;
    localparam logic [MAG_W-1:0]  SPEED_MAX  = 9'd255;

    // duty in the low bits, then forward, then reverse
    typedef struct packed {
        logic              reverse;
        logic              forward;
        logic [DUTY_W-1:0] duty;
    } bridge_t;

    typedef struct packed {
        logic [3:0] pad;
        bridge_t    right;
        bridge_t    left;
    } result_t;

endpackage

// ===== sv/motor_command_line_decoder.sv =====
// Decodes text lines "M,left,right" ended by a newline into two H-bridge drive
// settings. One byte enters per s_tvalid/s_tready word; each byte is parsed in the
// cycle it is accepted (whitespace skip, sign, digits with a multiply-by-ten add that
// saturates at 256), so the block takes a byte every cycle while s_tready is high. A
// newline that closes a line which has reached its right field yields one result
// word, registered on the master side; other bytes yield nothing. An output register
// backed by a one-word skid register lets input continue while a result waits;
// s_tready drops only when both hold a word. Speeds are clamped to 255; duty is the
// magnitude, forward/reverse give the sign, both low for zero.
module motor_command_line_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // left_duty[7:0], left_forward, left_reverse, right_duty[7:0],
    // right_forward, right_reverse, zero pad to 24 bits
    output logic [23:0] m_tdata
);

    typedef enum logic [2:0]
    {
        PH_START,
        PH_AFTER_M,
        PH_LEFT,
        PH_RIGHT,
        PH_REJECT
    } line_phase_t;

    typedef enum logic [1:0]
    {
        NP_BEFORE,
        NP_DIGITS,
        NP_DONE
    } number_phase_t;

    typedef struct packed {
        number_phase_t                 phase;
        logic [mcld_pkg::MAG_W-1:0]    mag;
        logic                          neg;
    } field_t;

    line_phase_t                  line_phase_reg, line_phase_next;
    number_phase_t                number_phase_reg, number_phase_next;
    logic [mcld_pkg::MAG_W-1:0]   left_mag_reg, left_mag_next;
    logic                         left_neg_reg, left_neg_next;
    logic [mcld_pkg::MAG_W-1:0]   right_mag_reg, right_mag_next;
    logic                         right_neg_reg, right_neg_next;

    logic                         out_valid_reg, out_valid_next;
    mcld_pkg::result_t            out_data_reg, out_data_next;
    logic                         skid_valid_reg, skid_valid_next;
    mcld_pkg::result_t            skid_data_reg, skid_data_next;

    logic                         accept;
    logic                         res_valid;
    mcld_pkg::result_t            res_data;
    field_t                       field_in;
    field_t                       field_out;
    logic [mcld_pkg::CHAR_W-1:0]  c;

    function automatic logic is_blank(input logic [mcld_pkg::CHAR_W-1:0] ch);
        return ch == mcld_pkg::CHAR_SPACE
            || (ch >= mcld_pkg::CHAR_TAB && ch <= mcld_pkg::CHAR_CR);
    endfunction

    // one byte of an atol-style field
    function automatic field_t field_byte(input logic [mcld_pkg::CHAR_W-1:0] ch,
                                          input field_t f);
        field_t                      r;
        logic                        digit;
        logic [11:0]                 v;
        number_phase_t               ph;
        r     = f;
        digit = (ch >= mcld_pkg::CHAR_ZERO) && (ch <= mcld_pkg::CHAR_NINE);
        v     = ({3'b000, f.mag} << 3) + ({3'b000, f.mag} << 1)
              + {4'b0000, ch - mcld_pkg::CHAR_ZERO};
        ph    = f.phase;
        if (ph == NP_BEFORE)
        begin
            if (is_blank(ch))
            begin
                ph = NP_BEFORE;
            end
            else if (ch == mcld_pkg::CHAR_PLUS || ch == mcld_pkg::CHAR_MINUS)
            begin
                r.neg   = (ch == mcld_pkg::CHAR_MINUS);
                r.phase = NP_DIGITS;
            end
            else if (!digit)
            begin
                r.phase = NP_DONE;
            end
            else
            begin
                ph      = NP_DIGITS;
                r.phase = NP_DIGITS;
            end
        end
        if (ph == NP_DIGITS && f.phase == ph)
        begin
            if (digit)
            begin
                r.mag = (v > 12'(mcld_pkg::MAG_SAT)) ? mcld_pkg::MAG_SAT : v[mcld_pkg::MAG_W-1:0];
            end
            else
            begin
                r.phase = NP_DONE;
            end
        end
        else if (ph == NP_DIGITS && digit)
        begin
            // first digit arriving straight from the before-sign phase
            r.mag = (v > 12'(mcld_pkg::MAG_SAT)) ? mcld_pkg::MAG_SAT : v[mcld_pkg::MAG_W-1:0];
        end
        return r;
    endfunction

    function automatic mcld_pkg::bridge_t drive(input logic [mcld_pkg::MAG_W-1:0] mag,
                                                input logic neg);
        mcld_pkg::bridge_t           b;
        logic [mcld_pkg::MAG_W-1:0]  m;
        m         = (mag > mcld_pkg::SPEED_MAX) ? mcld_pkg::SPEED_MAX : mag;
        b.duty    = m[mcld_pkg::DUTY_W-1:0];
        b.forward = (m != '0) && !neg;
        b.reverse = (m != '0) && neg;
        return b;
    endfunction

    assign c        = s_tdata;
    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        field_in.phase = number_phase_reg;
        field_in.mag   = (line_phase_reg == PH_RIGHT) ? right_mag_reg : left_mag_reg;
        field_in.neg   = (line_phase_reg == PH_RIGHT) ? right_neg_reg : left_neg_reg;
        field_out      = field_byte(c, field_in);
    end

    always_comb
    begin
        res_data.pad   = '0;
        res_data.left  = drive(left_mag_reg, left_neg_reg);
        res_data.right = drive(right_mag_reg, right_neg_reg);
        res_valid      = accept && (c == mcld_pkg::CHAR_NL) && (line_phase_reg == PH_RIGHT);
    end

    // parse state
    always_comb
    begin
        line_phase_next   = line_phase_reg;
        number_phase_next = number_phase_reg;
        left_mag_next     = left_mag_reg;
        left_neg_next     = left_neg_reg;
        right_mag_next    = right_mag_reg;
        right_neg_next    = right_neg_reg;
        if (accept)
        begin
            if (c == mcld_pkg::CHAR_NL)
            begin
                line_phase_next   = PH_START;
                number_phase_next = NP_BEFORE;
            end
            else
            begin
                case (line_phase_reg)
                    PH_START:
                    begin
                        if (is_blank(c))
                            line_phase_next = PH_START;
                        else if (c == mcld_pkg::CHAR_M)
                            line_phase_next = PH_AFTER_M;
                        else
                            line_phase_next = PH_REJECT;
                    end
                    PH_AFTER_M:
                    begin
                        if (c == mcld_pkg::CHAR_COMMA)
                        begin
                            line_phase_next   = PH_LEFT;
                            number_phase_next = NP_BEFORE;
                            left_mag_next     = '0;
                            left_neg_next     = 1'b0;
                        end
                    end
                    PH_LEFT:
                    begin
                        if (c == mcld_pkg::CHAR_COMMA)
                        begin
                            line_phase_next   = PH_RIGHT;
                            number_phase_next = NP_BEFORE;
                            right_mag_next    = '0;
                            right_neg_next    = 1'b0;
                        end
                        else
                        begin
                            number_phase_next = field_out.phase;
                            left_mag_next     = field_out.mag;
                            left_neg_next     = field_out.neg;
                        end
                    end
                    PH_RIGHT:
                    begin
                        number_phase_next = field_out.phase;
                        right_mag_next    = field_out.mag;
                        right_neg_next    = field_out.neg;
                    end
                    default:
                    begin
                        line_phase_next = PH_REJECT;
                    end
                endcase
            end
        end
    end

    // output register with skid word behind it
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = res_valid;
                skid_data_next  = res_data;
            end
            else
            begin
                out_valid_next = res_valid;
                out_data_next  = res_data;
            end
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_phase_reg   <= PH_START;
            number_phase_reg <= NP_BEFORE;
            left_mag_reg     <= '0;
            left_neg_reg     <= 1'b0;
            right_mag_reg    <= '0;
            right_neg_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            line_phase_reg   <= line_phase_next;
            number_phase_reg <= number_phase_next;
            left_mag_reg     <= left_mag_next;
            left_neg_reg     <= left_neg_next;
            right_mag_reg    <= right_mag_next;
            right_neg_reg    <= right_neg_next;
            out_valid_reg    <= out_valid_next;
            skid_valid_reg   <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ===== verif/tb_motor_command_line_decoder.sv =====
`timescale 1ns / 100ps

module tb_motor_command_line_decoder;

    typedef enum logic [2:0] {
        LN_START,
        LN_AFTER_M,
        LN_LEFT,
        LN_RIGHT,
        LN_REJECT
    } line_phase_t;

    typedef enum logic [1:0] {
        NUM_BEFORE,
        NUM_DIGITS,
        NUM_DONE
    } number_phase_t;

    // how the newline of a directed line is checked
    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_NONE,
        ROW_RESULT
    } row_kind_t;

    typedef struct packed {
        logic [mcld_pkg::DUTY_W-1:0] duty;
        logic                        fwd;
        logic                        rev;
    } bridge_drive_t;

    typedef struct packed {
        bridge_drive_t left;
        bridge_drive_t right;
    } drive_pair_t;

    typedef struct {
        string         text;
        row_kind_t     kind;
        drive_pair_t   want;
    } command_line_t;

    localparam bridge_drive_t ZERO_DRIVE = '0;
    localparam bridge_drive_t FULL_FWD   = {8'd255, 1'b1, 1'b0};
    localparam bridge_drive_t FULL_REV   = {8'd255, 1'b0, 1'b1};
    localparam logic [7:0]    BLANKS [5] = '{mcld_pkg::CHAR_TAB, 8'd11, 8'd12,
                                             mcld_pkg::CHAR_CR, mcld_pkg::CHAR_SPACE};
    localparam int unsigned   RANDOM_BYTES = 950;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    // predictor state
    line_phase_t   line_ph;
    number_phase_t num_ph;
    logic [8:0]    left_mag;
    logic          left_neg;
    logic [8:0]    right_mag;
    logic          right_neg;

    drive_pair_t   expected_drives[$];
    command_line_t directed_lines[$];
    logic [7:0]    line_buf[$];
    int unsigned   bytes_sent = 0;
    int unsigned   fail_count = 0;
    logic          no_idle = 1'b0;

    motor_command_line_decoder u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == mcld_pkg::CHAR_SPACE)
            || (c >= mcld_pkg::CHAR_TAB && c <= mcld_pkg::CHAR_CR);
    endfunction

    function automatic bridge_drive_t bridge_from_speed(input logic [8:0] mag, input logic neg);
        logic [8:0]    m;
        bridge_drive_t b;
        m      = (mag > mcld_pkg::SPEED_MAX) ? mcld_pkg::SPEED_MAX : mag;
        b.duty = m[7:0];
        b.fwd  = (m != 0) && !neg;
        b.rev  = (m != 0) && neg;
        return b;
    endfunction

    // atol-style digit accumulation, saturating at 256
    function automatic void take_field_char(input logic [7:0] c, inout logic [8:0] mag,
                                            inout logic neg);
        logic        digit;
        logic [11:0] v;
        digit = (c >= mcld_pkg::CHAR_ZERO) && (c <= mcld_pkg::CHAR_NINE);
        if (num_ph == NUM_BEFORE)
        begin
            if (is_blank(c))
                return;
            if (c == mcld_pkg::CHAR_PLUS || c == mcld_pkg::CHAR_MINUS)
            begin
                neg    = (c == mcld_pkg::CHAR_MINUS);
                num_ph = NUM_DIGITS;
                return;
            end
            if (!digit)
            begin
                num_ph = NUM_DONE;
                return;
            end
            num_ph = NUM_DIGITS;
        end
        if (num_ph == NUM_DIGITS)
        begin
            if (digit)
            begin
                v   = {3'b0, mag} * 12'd10 + {4'b0, c - mcld_pkg::CHAR_ZERO};
                mag = (v > mcld_pkg::MAG_SAT) ? mcld_pkg::MAG_SAT : v[8:0];
            end
            else
                num_ph = NUM_DONE;
        end
    endfunction

    function automatic logic decode_step(input logic [7:0] c, output drive_pair_t res);
        logic valid;
        res = '0;
        if (c == mcld_pkg::CHAR_NL)
        begin
            valid = (line_ph == LN_RIGHT);
            if (valid)
            begin
                res.left  = bridge_from_speed(left_mag, left_neg);
                res.right = bridge_from_speed(right_mag, right_neg);
            end
            line_ph = LN_START;
            num_ph  = NUM_BEFORE;
            return valid;
        end
        case (line_ph)
            LN_START:
                if (c == mcld_pkg::CHAR_M)
                    line_ph = LN_AFTER_M;
                else if (!is_blank(c))
                    line_ph = LN_REJECT;
            LN_AFTER_M:
                if (c == mcld_pkg::CHAR_COMMA)
                begin
                    line_ph  = LN_LEFT;
                    num_ph   = NUM_BEFORE;
                    left_mag = '0;
                    left_neg = 1'b0;
                end
            LN_LEFT:
                if (c == mcld_pkg::CHAR_COMMA)
                begin
                    line_ph   = LN_RIGHT;
                    num_ph    = NUM_BEFORE;
                    right_mag = '0;
                    right_neg = 1'b0;
                end
                else
                    take_field_char(c, left_mag, left_neg);
            LN_RIGHT:
                take_field_char(c, right_mag, right_neg);
            default:
                line_ph = LN_REJECT;
        endcase
        return 1'b0;
    endfunction

    function automatic void add_row(input string text, input row_kind_t kind,
                                    input bridge_drive_t l = '0, input bridge_drive_t r = '0);
        command_line_t row;
        row.text       = text;
        row.kind       = kind;
        row.want.left  = l;
        row.want.right = r;
        directed_lines.push_back(row);
    endfunction

    function automatic void put_blanks(input int unsigned max_n);
        repeat ($urandom_range(0, max_n))
            line_buf.push_back(BLANKS[$urandom_range(0, 4)]);
    endfunction

    function automatic void put_junk(input int unsigned max_n, input logic allow_comma);
        logic [7:0] b;
        repeat ($urandom_range(0, max_n))
        begin
            do
                b = 8'($urandom_range(0, 255));
            while (b == mcld_pkg::CHAR_NL || (!allow_comma && b == mcld_pkg::CHAR_COMMA));
            line_buf.push_back(b);
        end
    endfunction

    function automatic void put_field();
        int unsigned n;
        put_blanks(2);
        case ($urandom_range(0, 3))
            2: line_buf.push_back(mcld_pkg::CHAR_PLUS);
            3: line_buf.push_back(mcld_pkg::CHAR_MINUS);
            default: ;
        endcase
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 3);
        repeat (n)
            line_buf.push_back(mcld_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    // builds one line into line_buf: mostly well formed, some broken, some noise
    function automatic void build_line();
        logic [7:0] b;
        int unsigned kind;
        kind = $urandom_range(0, 9);
        line_buf.delete();
        if (kind == 9)
            put_junk(12, 1'b1);
        else
        begin
            put_blanks(2);
            if (kind == 8)
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (is_blank(b) || b == mcld_pkg::CHAR_M || b == mcld_pkg::CHAR_NL);
                line_buf.push_back(b);
            end
            else
                line_buf.push_back(mcld_pkg::CHAR_M);
            put_junk(2, 1'b0);
            line_buf.push_back(mcld_pkg::CHAR_COMMA);
            put_field();
            put_junk(2, 1'b0);
            if (kind != 7)
            begin
                line_buf.push_back(mcld_pkg::CHAR_COMMA);
                put_field();
                put_junk(3, 1'b1);
            end
        end
        line_buf.push_back(mcld_pkg::CHAR_NL);
    endfunction

    task automatic send_byte(input logic [7:0] c, input row_kind_t kind, input drive_pair_t typed);
        drive_pair_t predicted;
        logic        has_result;
        @(negedge clk);
        while (!no_idle && $urandom_range(0, 99) < 36)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do
            @(posedge clk);
        while (!s_tready);
        has_result = decode_step(c, predicted);
        if (c == mcld_pkg::CHAR_NL)
        begin
            case (kind)
                ROW_PREDICT: if (has_result) expected_drives.push_back(predicted);
                ROW_RESULT:  expected_drives.push_back(typed);
                default: ;
            endcase
        end
        bytes_sent++;
    endtask

    function automatic void check_bridge(input string side, input bridge_drive_t want,
                                         input bridge_drive_t got);
        if (want.duty !== got.duty)
        begin
            fail_count++;
            $display("%0t: %s duty expected %0d actual %0d", $time, side, want.duty,
                     got.duty);
        end
        if (want.fwd !== got.fwd)
        begin
            fail_count++;
            $display("%0t: %s forward expected %b actual %b", $time, side, want.fwd,
                     got.fwd);
        end
        if (want.rev !== got.rev)
        begin
            fail_count++;
            $display("%0t: %s reverse expected %b actual %b", $time, side, want.rev,
                     got.rev);
        end
    endfunction

    always @(negedge clk)
        m_tready <= no_idle || ($urandom_range(0, 99) >= 36);

    always @(posedge clk)
    begin : result_watch
        drive_pair_t want;
        drive_pair_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.left  = {m_tdata[7:0], m_tdata[8], m_tdata[9]};
            got.right = {m_tdata[17:10], m_tdata[18], m_tdata[19]};
            if (expected_drives.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected word, expected none actual %h", $time, m_tdata);
            end
            else
            begin
                want = expected_drives.pop_front();
                check_bridge("left", want.left, got.left);
                check_bridge("right", want.right, got.right);
                if (m_tdata[23:20] !== 4'b0)
                begin
                    fail_count++;
                    $display("%0t: pad expected 0 actual %h", $time, m_tdata[23:20]);
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("motor_command_line_decoder: mismatch");
        $finish;
    end

    initial
    begin
        int unsigned waited;
        line_ph   = LN_START;
        num_ph    = NUM_BEFORE;
        left_mag  = '0;
        left_neg  = 1'b0;
        right_mag = '0;
        right_neg = 1'b0;

        add_row("M,0,0", ROW_RESULT, ZERO_DRIVE, ZERO_DRIVE);
        add_row("M,255,-255", ROW_RESULT, FULL_FWD, FULL_REV);
        add_row("M,256,-99999", ROW_RESULT, FULL_FWD, FULL_REV);
        add_row("M,-0,+0", ROW_RESULT, ZERO_DRIVE, ZERO_DRIVE);
        add_row("M,,", ROW_RESULT, ZERO_DRIVE, ZERO_DRIVE);
        add_row("M,+,-x", ROW_RESULT, ZERO_DRIVE, ZERO_DRIVE);
        add_row("M,,-1000", ROW_RESULT, ZERO_DRIVE, FULL_REV);
        add_row("X,1,2", ROW_NONE);
        add_row("m,1,2", ROW_NONE);
        add_row(",M,1,2", ROW_NONE);
        add_row("M,5", ROW_NONE);
        add_row("", ROW_NONE);
        add_row(" \t ", ROW_NONE);
        add_row(" \tMxyz, 12abc,\t-7 8,9", ROW_PREDICT);
        add_row(" M , 3 , 4 ", ROW_PREDICT);
        add_row("M,1,2\015", ROW_PREDICT);
        add_row("MM,9,+250", ROW_PREDICT);
        add_row("M,1\3772,\377", ROW_PREDICT);
        add_row("\013\014M,-12,  -", ROW_PREDICT);
        add_row("M, - 5,007", ROW_PREDICT);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_lines[i])
        begin
            for (int k = 0; k < directed_lines[i].text.len(); k++)
                send_byte(directed_lines[i].text[k], directed_lines[i].kind,
                          directed_lines[i].want);
            send_byte(mcld_pkg::CHAR_NL, directed_lines[i].kind, directed_lines[i].want);
        end

        while (bytes_sent < RANDOM_BYTES)
        begin
            build_line();
            foreach (line_buf[k])
            begin
                // a stretch with no stalls on either side
                no_idle = (bytes_sent >= 350 && bytes_sent < 500);
                send_byte(line_buf[k], ROW_PREDICT, '0);
            end
        end
        no_idle = 1'b0;
        @(negedge clk);
        s_tvalid <= 1'b0;

        waited = 0;
        while (expected_drives.size() != 0 && waited < 10000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (expected_drives.size() != 0)
        begin
            fail_count++;
            $display("%0t: %0d words expected, actual none", $time, expected_drives.size());
        end

        if (fail_count == 0)
            $display("motor_command_line_decoder: match");
        else
            $display("motor_command_line_decoder: mismatch");
        $finish;
    end

endmodule
